FILE: rtl/assert_macros.svh
// assert_macros.svh: assertion macros shared by the allocator RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

FILE: rtl/ffha_pkg.sv
// ffha_pkg: constants, codes and controller/datapath command types of the heap allocator.
// Depends on nothing.
package ffha_pkg;

  localparam int unsigned HEAP_BYTES_DEF = 4096;
  localparam int unsigned HEADER_BYTES   = 8;
  localparam int unsigned ALIGN_BYTES    = 4;
  localparam int unsigned ALIGN_SH       = 2;

  localparam int unsigned REQ_W  = 12;
  localparam int unsigned OFS_W  = 12;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned FREE_W = 12;
  localparam int unsigned RQ_W   = REQ_W + 1;

  typedef enum logic {
    KIND_ALLOC   = 1'b0,
    KIND_RELEASE = 1'b1
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE    = 2'd0,
    ST_FAIL    = 2'd1,
    ST_IGNORED = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SPLIT,
    S_MERGE,
    S_RESP
  } state_e;

  typedef struct packed {
    logic    load;
    logic    start;
    logic    advance;
    logic    commit;
    logic    split_wr;
    logic    mrg_step;
    logic    mrg_end;
    logic    out_load;
    logic    res_pay;
    status_e res_status;
  } cmd_t;

  typedef struct packed {
    logic req_zero;
    logic rel_bad;
    logic in_end;
    logic fit_exact;
    logic fit_split;
    logic tgt_hit;
  } stat_t;

endpackage

FILE: rtl/ffha_if.sv
// ffha_if: valid/ready channels for allocator requests and results.
// Depends on ffha_pkg for field widths.
interface ffha_in_if;
  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic [ffha_pkg::REQ_W-1:0]       request_bytes;
  logic [ffha_pkg::OFS_W-1:0]       block_offset;

  modport source (output valid, kind, request_bytes, block_offset, input ready);
  modport sink   (input valid, kind, request_bytes, block_offset, output ready);
endinterface

interface ffha_out_if;
  logic                             valid;
  logic                             ready;
  logic [ffha_pkg::STAT_W-1:0]      status;
  logic [ffha_pkg::OFS_W-1:0]       payload_offset;
  logic [ffha_pkg::FREE_W-1:0]      free_bytes;

  modport source (output valid, status, payload_offset, free_bytes, input ready);
  modport sink   (input valid, status, payload_offset, free_bytes, output ready);
endinterface

FILE: rtl/first_fit_heap_allocator.sv
// first_fit_heap_allocator: first-fit heap allocator with split and coalesce, top level.
// Allocate: walks the blocks from the head to the first that fits, with a split step when
// the block has room for a new header; a zero size fails without a walk.
// Release: walks the whole chain (full merge and free recount); bad offsets skip the walk.
// Walk speed is one block header per cycle, set by the header memory read port.
// Reset: the heap is one free block at once; no clearing pass. One item at a time.
// Depends on ffha_pkg, ffha_if, ffha_ctrl and ffha_dp.
module first_fit_heap_allocator #(
  parameter int unsigned HEAP_BYTES = ffha_pkg::HEAP_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ffha_in_if.sink    in_i,
  ffha_out_if.source out_o
);

  ffha_pkg::cmd_t  cmd;
  ffha_pkg::stat_t stat;

  ffha_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_kind_i   (in_i.kind),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ffha_dp #(
    .HEAP_BYTES (HEAP_BYTES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .request_bytes_i  (in_i.request_bytes),
    .block_offset_i   (in_i.block_offset),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .status_o         (out_o.status),
    .payload_offset_o (out_o.payload_offset),
    .free_bytes_o     (out_o.free_bytes)
  );

endmodule

FILE: rtl/ffha_ctrl.sv
// ffha_ctrl: sequencer for allocate and release walks over the block chain.
// Depends on ffha_pkg and assert_macros.svh; drives ffha_dp through cmd_t / stat_t.
`include "assert_macros.svh"

module ffha_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_kind_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  ffha_pkg::stat_t  stat_i,
  output ffha_pkg::cmd_t   cmd_o
);

  ffha_pkg::state_e  state_q, state_d;
  ffha_pkg::status_e res_q, res_d;
  logic              alloc_q, alloc_d;
  logic              found_q, found_d;
  logic              out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ffha_pkg::S_IDLE;
      res_q       <= ffha_pkg::ST_DONE;
      alloc_q     <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_q       <= res_d;
      alloc_q     <= alloc_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d           = state_q;
    res_d             = res_q;
    alloc_d           = alloc_q;
    found_d           = found_q;
    out_valid_d       = out_valid_q && !out_ready_i;
    in_ready_o        = 1'b0;
    cmd_o             = '0;
    cmd_o.res_status  = res_q;
    unique case (state_q)
      ffha_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          found_d    = 1'b0;
          alloc_d    = (in_kind_i == ffha_pkg::KIND_ALLOC);
          res_d      = ffha_pkg::ST_DONE;
          if (in_kind_i == ffha_pkg::KIND_ALLOC) begin
            if (stat_i.req_zero) begin
              res_d   = ffha_pkg::ST_FAIL;
              state_d = ffha_pkg::S_RESP;
            end else begin
              cmd_o.start = 1'b1;
              state_d     = ffha_pkg::S_SEARCH;
            end
          end else begin
            if (stat_i.rel_bad) begin
              res_d   = ffha_pkg::ST_IGNORED;
              state_d = ffha_pkg::S_RESP;
            end else begin
              cmd_o.start = 1'b1;
              state_d     = ffha_pkg::S_MERGE;
            end
          end
        end
      end
      ffha_pkg::S_SEARCH: begin
        if (stat_i.in_end) begin
          res_d   = ffha_pkg::ST_FAIL;
          state_d = ffha_pkg::S_RESP;
        end else if (stat_i.fit_exact) begin
          cmd_o.commit = 1'b1;
          res_d        = ffha_pkg::ST_DONE;
          state_d      = ffha_pkg::S_RESP;
        end else if (stat_i.fit_split) begin
          cmd_o.commit = 1'b1;
          state_d      = ffha_pkg::S_SPLIT;
        end else begin
          cmd_o.advance = 1'b1;
        end
      end
      ffha_pkg::S_SPLIT: begin
        cmd_o.split_wr = 1'b1;
        res_d          = ffha_pkg::ST_DONE;
        state_d        = ffha_pkg::S_RESP;
      end
      ffha_pkg::S_MERGE: begin
        if (stat_i.in_end) begin
          cmd_o.mrg_end = 1'b1;
          res_d         = found_q ? ffha_pkg::ST_DONE : ffha_pkg::ST_IGNORED;
          state_d       = ffha_pkg::S_RESP;
        end else begin
          cmd_o.mrg_step = 1'b1;
          cmd_o.advance  = 1'b1;
          if (stat_i.tgt_hit) begin
            found_d = 1'b1;
          end
        end
      end
      ffha_pkg::S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          cmd_o.res_pay  = alloc_q && (res_q == ffha_pkg::ST_DONE);
          out_valid_d    = 1'b1;
          state_d        = ffha_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ffha_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  `ASSERT_PROP(a_walk_kind, clk_i, rst_ni, (state_q == ffha_pkg::S_SEARCH || state_q == ffha_pkg::S_SPLIT) |-> alloc_q, "allocate walk entered for a release")
  `ASSERT_NEVER(a_load_over, clk_i, rst_ni, cmd_o.out_load && out_valid_q && !out_ready_i, "result loaded over an untaken result")

endmodule

FILE: rtl/ffha_dp.sv
// ffha_dp: header memory, chain walk pointer, merge run tracking and result register.
// Depends on ffha_pkg and assert_macros.svh; commanded by ffha_ctrl.
`include "assert_macros.svh"

module ffha_dp #(
  parameter int unsigned HEAP_BYTES = ffha_pkg::HEAP_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ffha_pkg::REQ_W-1:0]    request_bytes_i,
  input  logic [ffha_pkg::OFS_W-1:0]    block_offset_i,
  input  ffha_pkg::cmd_t                cmd_i,
  output ffha_pkg::stat_t               stat_o,
  output logic [ffha_pkg::STAT_W-1:0]   status_o,
  output logic [ffha_pkg::OFS_W-1:0]    payload_offset_o,
  output logic [ffha_pkg::FREE_W-1:0]   free_bytes_o
);

  localparam int unsigned WORDS    = HEAP_BYTES / ffha_pkg::ALIGN_BYTES;
  localparam int unsigned HEAP_USE = WORDS * ffha_pkg::ALIGN_BYTES;
  localparam int unsigned LAST_POS = HEAP_USE - ffha_pkg::HEADER_BYTES;
  localparam int unsigned POS_W    = $clog2(HEAP_USE + 1);
  localparam int unsigned SZ_W     = $clog2(HEAP_BYTES);
  localparam int unsigned IDX_W    = $clog2(WORDS);
  localparam int unsigned NW       = POS_W + 1;
  localparam int unsigned CW       = ((SZ_W > ffha_pkg::RQ_W) ? SZ_W : ffha_pkg::RQ_W) + 1;
  localparam int unsigned PX       = ((POS_W > ffha_pkg::RQ_W) ? POS_W : ffha_pkg::RQ_W) + 1;
  localparam int unsigned XW       = ((POS_W > ffha_pkg::OFS_W) ? POS_W : ffha_pkg::OFS_W) + 1;
  localparam int unsigned FW       = (SZ_W > ffha_pkg::FREE_W) ? SZ_W : ffha_pkg::FREE_W;

  typedef struct packed {
    logic            used;
    logic [SZ_W-1:0] size;
  } hdr_t;

  hdr_t                      mem [WORDS];
  hdr_t                      mem_rd_q;
  hdr_t                      head_q;
  hdr_t                      head_snap_q;
  logic                      head_sel_q;
  logic [POS_W-1:0]          pos_q;
  logic [ffha_pkg::RQ_W-1:0] rq_q;
  logic [POS_W-1:0]          st_q;
  logic                      run_act_q;
  logic [POS_W-1:0]          run_pos_q;
  logic [SZ_W-1:0]           run_size_q;
  logic [SZ_W-1:0]           sum_q;
  logic [SZ_W-1:0]           free_q;
  logic [ffha_pkg::STAT_W-1:0] status_q;
  logic [ffha_pkg::OFS_W-1:0]  pay_q;
  logic [ffha_pkg::FREE_W-1:0] freeb_q;

  hdr_t                      ent;
  logic [NW-1:0]             nxt_x;
  logic [POS_W-1:0]          nxt;
  logic                      nxt_ok;
  logic                      in_end;
  logic [CW-1:0]             size_x;
  logic [CW-1:0]             rq_x;
  logic                      fit_exact;
  logic                      fit_split;
  logic                      is_tgt;
  logic                      eff_free;
  logic [PX-1:0]             sp_x;
  logic [SZ_W-1:0]           rem;
  logic [ffha_pkg::RQ_W-1:0] rq_in;
  logic [XW-1:0]             ofs_x;
  logic [XW-1:0]             st_x;
  logic [XW-1:0]             pay_x;
  logic [FW-1:0]             fb_x;
  logic                      we;
  logic [POS_W-1:0]          wpos;
  hdr_t                      wdat;
  logic                      re;
  logic [POS_W-1:0]          rpos;
  logic [IDX_W-1:0]          widx;
  logic [IDX_W-1:0]          ridx;

  assign ent       = head_sel_q ? head_snap_q : mem_rd_q;
  assign nxt_x     = NW'(pos_q) + NW'(ffha_pkg::HEADER_BYTES) + NW'(ent.size);
  assign nxt       = nxt_x[POS_W-1:0];
  assign nxt_ok    = nxt_x <= NW'(LAST_POS);
  assign in_end    = pos_q > POS_W'(LAST_POS);
  assign size_x    = CW'(ent.size);
  assign rq_x      = CW'(rq_q);
  assign fit_exact = !ent.used && (size_x == rq_x);
  assign fit_split = !ent.used && (size_x >= rq_x + CW'(ffha_pkg::HEADER_BYTES));
  assign is_tgt    = (pos_q == st_q);
  assign eff_free  = !ent.used || is_tgt;
  assign sp_x      = PX'(pos_q) + PX'(ffha_pkg::HEADER_BYTES) + PX'(rq_q);
  assign rem       = ent.size - SZ_W'(rq_q) - SZ_W'(ffha_pkg::HEADER_BYTES);

  assign rq_in = (ffha_pkg::RQ_W'(request_bytes_i) + ffha_pkg::RQ_W'(ffha_pkg::ALIGN_BYTES - 1))
                 & ~ffha_pkg::RQ_W'(ffha_pkg::ALIGN_BYTES - 1);
  assign ofs_x = XW'(block_offset_i);
  assign st_x  = ofs_x - XW'(ffha_pkg::HEADER_BYTES);
  assign pay_x = XW'(pos_q) + XW'(ffha_pkg::HEADER_BYTES);
  assign fb_x  = FW'(free_q);

  assign stat_o.req_zero  = (request_bytes_i == '0);
  assign stat_o.rel_bad   = (ofs_x < XW'(ffha_pkg::HEADER_BYTES)) || (ofs_x > XW'(LAST_POS))
                            || (block_offset_i[ffha_pkg::ALIGN_SH-1:0] != '0);
  assign stat_o.in_end    = in_end;
  assign stat_o.fit_exact = fit_exact;
  assign stat_o.fit_split = fit_split;
  assign stat_o.tgt_hit   = is_tgt && ent.used;

  always_comb begin
    we   = 1'b0;
    wpos = pos_q;
    wdat = '{used: 1'b1, size: ent.size};
    if (cmd_i.commit) begin
      we   = 1'b1;
      wdat = '{used: 1'b1, size: (fit_exact ? ent.size : SZ_W'(rq_q))};
    end else if (cmd_i.split_wr) begin
      we   = 1'b1;
      wpos = sp_x[POS_W-1:0];
      wdat = '{used: 1'b0, size: rem};
    end else if ((cmd_i.mrg_step && !eff_free && run_act_q) || (cmd_i.mrg_end && run_act_q)) begin
      we   = 1'b1;
      wpos = run_pos_q;
      wdat = '{used: 1'b0, size: run_size_q};
    end
  end

  always_comb begin
    re   = 1'b0;
    rpos = nxt;
    if (cmd_i.start) begin
      re   = 1'b1;
      rpos = '0;
    end else if (cmd_i.advance) begin
      re   = nxt_ok;
    end
  end

  assign widx = wpos[ffha_pkg::ALIGN_SH +: IDX_W];
  assign ridx = rpos[ffha_pkg::ALIGN_SH +: IDX_W];

  always_ff @(posedge clk_i) begin
    if (we && (wpos != '0)) begin
      mem[widx] <= wdat;
    end
    if (re) begin
      mem_rd_q <= mem[ridx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      head_snap_q <= head_q;
      head_sel_q  <= (rpos == '0);
    end
    if (cmd_i.load) begin
      rq_q <= rq_in;
      st_q <= st_x[POS_W-1:0];
    end
    if (cmd_i.out_load) begin
      status_q <= cmd_i.res_status;
      pay_q    <= cmd_i.res_pay ? pay_x[ffha_pkg::OFS_W-1:0] : '0;
      freeb_q  <= fb_x[ffha_pkg::FREE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '{used: 1'b0, size: SZ_W'(LAST_POS)};
      free_q     <= SZ_W'(LAST_POS);
      pos_q      <= '0;
      run_act_q  <= 1'b0;
      run_pos_q  <= '0;
      run_size_q <= '0;
      sum_q      <= '0;
    end else begin
      if (we && (wpos == '0)) begin
        head_q <= wdat;
      end
      if (cmd_i.start) begin
        pos_q     <= '0;
        run_act_q <= 1'b0;
        sum_q     <= '0;
      end else if (cmd_i.advance) begin
        pos_q <= nxt;
      end
      if (cmd_i.commit) begin
        free_q <= free_q - (fit_exact ? ent.size
                                      : SZ_W'(rq_q) + SZ_W'(ffha_pkg::HEADER_BYTES));
      end
      if (cmd_i.mrg_step) begin
        if (eff_free) begin
          if (run_act_q) begin
            run_size_q <= run_size_q + ent.size + SZ_W'(ffha_pkg::HEADER_BYTES);
          end else begin
            run_act_q  <= 1'b1;
            run_pos_q  <= pos_q;
            run_size_q <= ent.size;
          end
        end else if (run_act_q) begin
          sum_q     <= sum_q + run_size_q;
          run_act_q <= 1'b0;
        end
      end
      if (cmd_i.mrg_end) begin
        free_q    <= sum_q + (run_act_q ? run_size_q : '0);
        run_act_q <= 1'b0;
      end
    end
  end

  assign status_o         = status_q;
  assign payload_offset_o = pay_q;
  assign free_bytes_o     = freeb_q;

  `ASSERT_PROP(a_one_write, clk_i, rst_ni, $onehot0({cmd_i.commit, cmd_i.split_wr, cmd_i.mrg_step, cmd_i.mrg_end}), "conflicting header writes")
  `ASSERT_PROP(a_free_bound, clk_i, rst_ni, free_q <= SZ_W'(LAST_POS), "free total beyond heap payload")
  `ASSERT_PROP(a_pos_word, clk_i, rst_ni, (pos_q[ffha_pkg::ALIGN_SH-1:0] == '0) && (pos_q <= POS_W'(HEAP_USE)), "walk pointer off the heap or misaligned")

endmodule

FILE: dv/ffha_heap_checker.sv
`timescale 1ns / 1ps
// ffha_heap_checker: predicts every allocator result from its own copy of the heap headers
// and compares the results that come out, field by field. Depends on ffha_pkg and ffha_if.
module ffha_heap_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  ffha_in_if          in_ch,
  ffha_out_if         out_ch,
  output int unsigned fail_count_o
);
  import ffha_pkg::*;

  localparam int unsigned HEAP_WORDS = HEAP_BYTES_DEF / ALIGN_BYTES;
  localparam int unsigned HEAP_SPAN  = HEAP_WORDS * ALIGN_BYTES;

  typedef struct packed {
    status_e             status;
    logic [OFS_W-1:0]    payload;
    logic [FREE_W-1:0]   free_bytes;
  } heap_answer_t;

  bit           blk_start [HEAP_WORDS];
  bit           blk_used  [HEAP_WORDS];
  int unsigned  blk_size  [HEAP_WORDS];
  heap_answer_t answer_q [$];
  heap_answer_t want;
  int unsigned  mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic int unsigned next_block(int unsigned pos);
    return pos + HEADER_BYTES + blk_size[pos / ALIGN_BYTES];
  endfunction

  function automatic int unsigned free_payload_sum();
    int unsigned pos;
    int unsigned total;
    pos = 0;
    total = 0;
    while (pos + HEADER_BYTES <= HEAP_SPAN) begin
      if (!blk_used[pos / ALIGN_BYTES]) total += blk_size[pos / ALIGN_BYTES];
      pos = next_block(pos);
    end
    return total;
  endfunction

  function automatic void coalesce_free();
    int unsigned pos;
    int unsigned nx;
    pos = 0;
    while (pos + HEADER_BYTES <= HEAP_SPAN) begin
      if (!blk_used[pos / ALIGN_BYTES]) begin
        nx = next_block(pos);
        while (nx + HEADER_BYTES <= HEAP_SPAN && !blk_used[nx / ALIGN_BYTES]) begin
          blk_size[pos / ALIGN_BYTES] += blk_size[nx / ALIGN_BYTES] + HEADER_BYTES;
          blk_start[nx / ALIGN_BYTES] = 1'b0;
          blk_used[nx / ALIGN_BYTES]  = 1'b0;
          blk_size[nx / ALIGN_BYTES]  = 0;
          nx = next_block(pos);
        end
      end
      pos = next_block(pos);
    end
  endfunction

  function automatic status_e alloc_first_fit(int unsigned req, output int unsigned payload);
    int unsigned need;
    int unsigned pos;
    int unsigned w;
    int unsigned np;
    payload = 0;
    if (req == 0) return ST_FAIL;
    need = (req + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
    pos = 0;
    while (pos + HEADER_BYTES <= HEAP_SPAN) begin
      w = pos / ALIGN_BYTES;
      if (!blk_used[w]) begin
        if (blk_size[w] == need) begin
          blk_used[w] = 1'b1;
          payload = pos + HEADER_BYTES;
          return ST_DONE;
        end
        if (blk_size[w] >= need + HEADER_BYTES) begin
          np = pos + HEADER_BYTES + need;
          blk_start[np / ALIGN_BYTES] = 1'b1;
          blk_used[np / ALIGN_BYTES]  = 1'b0;
          blk_size[np / ALIGN_BYTES]  = blk_size[w] - need - HEADER_BYTES;
          blk_used[w] = 1'b1;
          blk_size[w] = need;
          payload = pos + HEADER_BYTES;
          return ST_DONE;
        end
      end
      pos = next_block(pos);
    end
    return ST_FAIL;
  endfunction

  function automatic status_e release_block(int unsigned ofs);
    int unsigned st;
    if (ofs < HEADER_BYTES || ofs > HEAP_SPAN - HEADER_BYTES) return ST_IGNORED;
    st = ofs - HEADER_BYTES;
    if (st % ALIGN_BYTES != 0) return ST_IGNORED;
    if (!blk_start[st / ALIGN_BYTES] || !blk_used[st / ALIGN_BYTES]) return ST_IGNORED;
    blk_used[st / ALIGN_BYTES] = 1'b0;
    coalesce_free();
    return ST_DONE;
  endfunction

  function automatic heap_answer_t apply_heap_op(kind_e kind, int unsigned req, int unsigned ofs);
    heap_answer_t ans;
    int unsigned payload;
    payload = 0;
    if (kind == KIND_ALLOC) ans.status = alloc_first_fit(req, payload);
    else ans.status = release_block(ofs);
    ans.payload    = (ans.status == ST_DONE) ? payload[OFS_W-1:0] : '0;
    ans.free_bytes = FREE_W'(free_payload_sum());
    return ans;
  endfunction

  function automatic void reset_heap();
    for (int unsigned w = 0; w < HEAP_WORDS; w++) begin
      blk_start[w] = 1'b0;
      blk_used[w]  = 1'b0;
      blk_size[w]  = 0;
    end
    blk_start[0] = 1'b1;
    blk_size[0]  = HEAP_SPAN - HEADER_BYTES;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned exp);
    $display("%0t: %s mismatch, got %0d, want %0d", $realtime, what, got, exp);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_heap();
      answer_q.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        answer_q.push_back(apply_heap_op(kind_e'(in_ch.kind), 32'(in_ch.request_bytes),
                                         32'(in_ch.block_offset)));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (answer_q.size() == 0) begin
          report_mismatch("unrequested result status", 32'(out_ch.status), 0);
        end else begin
          want = answer_q.pop_front();
          if (out_ch.status !== want.status)
            report_mismatch("status", 32'(out_ch.status), 32'(want.status));
          if (out_ch.payload_offset !== want.payload)
            report_mismatch("payload_offset", 32'(out_ch.payload_offset), 32'(want.payload));
          if (out_ch.free_bytes !== want.free_bytes)
            report_mismatch("free_bytes", 32'(out_ch.free_bytes), 32'(want.free_bytes));
        end
      end
    end
  end

endmodule

FILE: dv/first_fit_heap_allocator_tb.sv
`timescale 1ns / 1ps
// first_fit_heap_allocator_tb: drives directed and random allocate/release traffic with
// random idling on both channels; ffha_heap_checker predicts and compares. Depends on ffha_pkg.
module first_fit_heap_allocator_tb;
  import ffha_pkg::*;

  localparam int unsigned RANDOM_OPS   = 1750;
  localparam int unsigned CYCLE_LIMIT  = 4000000;
  localparam int unsigned DRAIN_CYCLES = 1200;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned fail_count;
  int unsigned cycle_count = 0;
  int unsigned sent_ops = 0;
  int unsigned done_ops = 0;
  bit          no_idle = 1'b0;
  logic [OFS_W-1:0] live_ofs [$];
  kind_e       kinds_in_flight [$];
  kind_e       done_kind;
  logic [OFS_W-1:0] last_released = '0;
  int unsigned pick;
  int unsigned idx;

  ffha_in_if  in_ch ();
  ffha_out_if out_ch ();

  first_fit_heap_allocator uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  ffha_heap_checker heap_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .fail_count_o (fail_count)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_ch.ready <= no_idle || ($urandom_range(99) >= 35);
    end
  end

  // track live payloads from completed allocations
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      done_kind = kinds_in_flight.pop_front();
      if (done_kind == KIND_ALLOC && out_ch.status == ST_DONE)
        live_ofs.push_back(out_ch.payload_offset);
      done_ops++;
    end
  end

  task automatic push_op(kind_e kind, logic [REQ_W-1:0] req, logic [OFS_W-1:0] ofs);
    int unsigned j;
    if (!no_idle && $urandom_range(99) < 35) begin
      in_ch.valid <= 1'b0;
      repeat (($urandom_range(9) == 0) ? $urandom_range(8, 60) : $urandom_range(1, 3))
        @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.kind          <= kind;
    in_ch.request_bytes <= req;
    in_ch.block_offset  <= ofs;
    do @(negedge clk_i); while (!in_ch.ready);
    @(posedge clk_i);
    kinds_in_flight.push_back(kind);
    sent_ops++;
    if (kind == KIND_RELEASE) begin
      j = 0;
      while (j < live_ofs.size()) begin
        if (live_ofs[j] == ofs) live_ofs.delete(j);
        else j++;
      end
    end
  endtask

  task automatic alloc_op(logic [REQ_W-1:0] req);
    push_op(KIND_ALLOC, req, OFS_W'($urandom));
  endtask

  task automatic release_op(logic [OFS_W-1:0] ofs);
    push_op(KIND_RELEASE, REQ_W'($urandom), ofs);
  endtask

  // hold the request channel until every outstanding transfer has its result
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (sent_ops != done_ops);
  endtask

  function automatic logic [REQ_W-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return REQ_W'($urandom_range(1, 64));
    if (r < 88) return REQ_W'($urandom_range(1, 256));
    if (r < 97) return REQ_W'($urandom_range(257, 1500));
    return REQ_W'($urandom_range(1501, 4095));
  endfunction

  initial begin
    in_ch.valid         <= 1'b0;
    in_ch.kind          <= KIND_ALLOC;
    in_ch.request_bytes <= '0;
    in_ch.block_offset  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    alloc_op(12'd0);
    alloc_op(12'd4095);
    alloc_op(12'd1);
    alloc_op(12'd13);
    alloc_op(12'd4);
    release_op(12'd20);
    release_op(12'd20);
    alloc_op(12'd16);
    release_op(12'd7);
    release_op(12'd4092);
    release_op(12'd22);
    release_op(12'd24);
    release_op(12'd0);
    release_op(12'd4095);
    release_op(12'd4088);
    alloc_op(12'd4032);
    alloc_op(12'd4);
    release_op(12'd56);
    release_op(12'd8);
    release_op(12'd44);
    release_op(12'd20);
    alloc_op(12'd4085);
    release_op(12'd8);
    drain();

    for (int unsigned i = 0; i < RANDOM_OPS; i++) begin
      no_idle = (i >= 700 && i < 1000);
      if (i == 850) drain();
      pick = $urandom_range(99);
      if (pick < 7) begin
        alloc_op(REQ_W'($urandom));
      end else if (pick < 14) begin
        release_op(OFS_W'($urandom));
      end else if (pick < 17) begin
        release_op(OFS_W'($urandom_range(1023)) << ALIGN_SH);
      end else if (pick < 19) begin
        release_op(last_released);
      end else if (live_ofs.size() > 0 &&
                   $urandom_range(99) < ((live_ofs.size() > 24) ? 65 : 35)) begin
        idx = $urandom_range(live_ofs.size() - 1);
        last_released = live_ofs[idx];
        release_op(last_released);
      end else begin
        alloc_op(pick_size());
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
